>>> design/nested_rectangle_filter_top_assert.svh
// Assertion macros for the nested rectangle filter, clocked on clock, quiet in reset.
`ifndef NESTED_RECTANGLE_FILTER_TOP_ASSERT_SVH
`define NESTED_RECTANGLE_FILTER_TOP_ASSERT_SVH

// Condition holds at every edge.
`define NRF_ASSERT_ALWAYS(name, cond) \
   name: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("nested rectangle filter: invariant violated");

// Consequence holds in the same cycle as the antecedent.
`define NRF_ASSERT_IMPLY(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("nested rectangle filter: implication violated");

// Consequence holds in the cycle after the antecedent.
`define NRF_ASSERT_NEXT(name, pre, post) \
   name: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("nested rectangle filter: next-cycle check violated");

`endif

>>> design/nrf_pkg.sv
// Package of the nested rectangle filter: rectangle type, states and containment test.
`default_nettype none

package nrf_pkg;

   localparam int MAX_RECTS_DEF = 64;
   localparam int RECT_W        = 48;

   typedef struct packed {
      logic signed [11:0] x;
      logic signed [11:0] y;
      logic [11:0]        w;
      logic [11:0]        h;
   } rect_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_READ_I,
      ST_LATCH_I,
      ST_SCAN,
      ST_DECIDE,
      ST_FINAL
   } nrf_state_type;

   // True when the intersection of a and b equals a; an empty overlap is (0,0,0,0).
   function automatic logic rect_inside(input rect_type a, input rect_type b);
      logic signed [13:0] ax, ay, aw, ah, bx, by, bw, bh;
      logic signed [13:0] sx, sy, ex, ey, sw, sh, a_ex, b_ex, a_ey, b_ey;
      ax = {{2{a.x[11]}}, a.x};
      ay = {{2{a.y[11]}}, a.y};
      aw = {2'b00, a.w};
      ah = {2'b00, a.h};
      bx = {{2{b.x[11]}}, b.x};
      by = {{2{b.y[11]}}, b.y};
      bw = {2'b00, b.w};
      bh = {2'b00, b.h};
      sx = (ax > bx) ? ax : bx;
      sy = (ay > by) ? ay : by;
      a_ex = ax + aw;
      b_ex = bx + bw;
      a_ey = ay + ah;
      b_ey = by + bh;
      ex = (a_ex < b_ex) ? a_ex : b_ex;
      ey = (a_ey < b_ey) ? a_ey : b_ey;
      sw = ex - sx;
      sh = ey - sy;
      // collapse an empty overlap to the null rectangle
      if (sw <= 14'sd0 || sh <= 14'sd0) begin
         sx = '0;
         sy = '0;
         sw = '0;
         sh = '0;
      end
      return (sx == ax) && (sy == ay) && (sw == aw) && (sh == ah);
   endfunction

endpackage

`default_nettype wire

>>> design/nrf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module nrf_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write on enable, read every cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/nested_rectangle_filter_top.sv
// Top level of the nested rectangle filter: load control, pairwise scan and result register.
`default_nettype none

// Nested rectangle filter. Requests carry one rectangle each and are stored in
// order, one per cycle, until a request marked last_in; beyond MAX_RECTS entries
// rectangles are dropped and every result of the set reports overflow. After the
// last request the block takes no request while it filters: for each of the n
// stored rectangles it reads the entry, then streams all n entries through the
// single read port of the store memory and tests containment; a result stall
// can hold the filtering up. Survivors leave in load order, the final one with
// last_out; an empty set of survivors gives one result with valid_res clear. The
// store needs no clearing after reset.
module nested_rectangle_filter_top
   import nrf_pkg::*;
#(
   parameter int MAX_RECTS = MAX_RECTS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [11:0] req_rect_x,
   input  wire logic signed [11:0] req_rect_y,
   input  wire logic        [11:0] req_rect_w,
   input  wire logic        [11:0] req_rect_h,
   input  wire logic               req_last_in,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed      [11:0] rsp_out_x,
   output logic signed      [11:0] rsp_out_y,
   output logic             [11:0] rsp_out_w,
   output logic             [11:0] rsp_out_h,
   output logic                    rsp_valid_res,
   output logic                    rsp_overflow,
   output logic                    rsp_last_out
);

   localparam int ADDR_W = $clog2(MAX_RECTS);
   localparam int CNT_W  = $clog2(MAX_RECTS + 1);

   nrf_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic              cmp_v_ff, cmp_v_in;
   logic [ADDR_W-1:0] cmp_idx_ff, cmp_idx_in;
   logic              drop_ff, drop_in;
   rect_type          cur_ff, cur_in;
   logic              pend_v_ff, pend_v_in;
   rect_type          pend_ff, pend_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rect_type          rsp_rect_ff, rsp_rect_in;
   logic              rsp_res_ff, rsp_res_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              req_accept;
   logic              room;
   logic              slot_free;
   logic              last_i;
   logic              advance;
   logic              wr_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [RECT_W-1:0] rd_data;
   rect_type          rd_rect;
   rect_type          wr_rect;

   assign req_accept = req_valid && (state_ff == ST_LOAD);
   assign room       = count_ff < CNT_W'(MAX_RECTS);
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign last_i     = (CNT_W'(i_ff) + CNT_W'(1)) == count_ff;
   assign wr_en      = req_accept && room;
   assign rd_addr    = (state_ff == ST_READ_I) ? i_ff : j_ff[ADDR_W-1:0];
   assign rd_rect    = rect_type'(rd_data);

   always_comb begin
      wr_rect.x = req_rect_x;
      wr_rect.y = req_rect_y;
      wr_rect.w = req_rect_w;
      wr_rect.h = req_rect_h;
   end

   // rectangle store
   nrf_ram #(
      .WIDTH (RECT_W),
      .DEPTH (MAX_RECTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (wr_rect),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // next state, scan control and result push
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      cmp_v_in     = cmp_v_ff;
      cmp_idx_in   = cmp_idx_ff;
      drop_in      = drop_ff;
      cur_in       = cur_ff;
      pend_v_in    = pend_v_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rect_in  = rsp_rect_ff;
      rsp_res_in   = rsp_res_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_last_in  = rsp_last_ff;
      advance      = 1'b0;

      case (state_ff)
         ST_LOAD: begin
            // store the request or flag it as dropped
            if (req_valid) begin
               if (room) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_in) begin
                  i_in     = '0;
                  state_in = ST_READ_I;
               end
            end
         end
         ST_READ_I: begin
            state_in = ST_LATCH_I;
         end
         ST_LATCH_I: begin
            cur_in   = rd_rect;
            j_in     = '0;
            cmp_v_in = 1'b0;
            drop_in  = 1'b0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // issue the next read
            if (j_ff < count_ff) begin
               cmp_v_in   = 1'b1;
               cmp_idx_in = j_ff[ADDR_W-1:0];
               j_in       = j_ff + CNT_W'(1);
            end else begin
               cmp_v_in = 1'b0;
            end
            // test the entry that arrived
            if (cmp_v_ff && (cmp_idx_ff != i_ff) && rect_inside(cur_ff, rd_rect)) begin
               drop_in = 1'b1;
            end
            if ((j_ff == count_ff) && !cmp_v_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            // hold one survivor back so the final one can carry last_out
            if (drop_ff) begin
               advance = 1'b1;
            end else if (!pend_v_ff) begin
               pend_in   = cur_ff;
               pend_v_in = 1'b1;
               advance   = 1'b1;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_rect_in  = pend_ff;
               rsp_res_in   = 1'b1;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = 1'b0;
               pend_in      = cur_ff;
               advance      = 1'b1;
            end
            if (advance) begin
               if (last_i) begin
                  state_in = ST_FINAL;
               end else begin
                  i_in     = i_ff + ADDR_W'(1);
                  state_in = ST_READ_I;
               end
            end
         end
         ST_FINAL: begin
            // emit the final result and empty the store
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_rect_in  = pend_v_ff ? pend_ff : '0;
               rsp_res_in   = pend_v_ff;
               rsp_ovf_in   = ovf_ff;
               rsp_last_in  = 1'b1;
               pend_v_in    = 1'b0;
               count_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         i_ff         <= '0;
         j_ff         <= '0;
         cmp_v_ff     <= 1'b0;
         drop_ff      <= 1'b0;
         pend_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         cmp_v_ff     <= cmp_v_in;
         drop_ff      <= drop_in;
         pend_v_ff    <= pend_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      cur_ff      <= cur_in;
      pend_ff     <= pend_in;
      rsp_rect_ff <= rsp_rect_in;
      rsp_res_ff  <= rsp_res_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_stall     = (state_ff != ST_LOAD);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_x     = rsp_rect_ff.x;
   assign rsp_out_y     = rsp_rect_ff.y;
   assign rsp_out_w     = rsp_rect_ff.w;
   assign rsp_out_h     = rsp_rect_ff.h;
   assign rsp_valid_res = rsp_res_ff;
   assign rsp_overflow  = rsp_ovf_ff;
   assign rsp_last_out  = rsp_last_ff;

`include "nested_rectangle_filter_top_assert.svh"

   `NRF_ASSERT_ALWAYS(a_count_bound, count_ff <= CNT_W'(MAX_RECTS))
   `NRF_ASSERT_IMPLY(a_empty_is_last, rsp_valid && !rsp_valid_res, rsp_last_out)
   `NRF_ASSERT_IMPLY(a_no_pending_in_load, state_ff == ST_LOAD, !pend_v_ff)
   `NRF_ASSERT_NEXT(a_final_clears, (state_ff == ST_FINAL) && slot_free,
                    (count_ff == '0) && !ovf_ff && rsp_valid && rsp_last_out)

endmodule

`default_nettype wire
